### rtl/kpe_pkg.sv
package kpe_pkg;

  // Largest set size the walk supports; register values above it saturate.
  localparam int MAX_N     = 8;
  // Number of element fields shown on the result channel.
  localparam int NUM_ELEMS = 8;
  // Width of an element field and of a configuration register.
  localparam int ELEM_W    = 4;
  // Width of a value or position count (0..MAX_N).
  localparam int CNT_W     = $clog2(MAX_N + 1);
  // Width of a stack index (0..MAX_N-1).
  localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [MAX_N-1:0] vmask_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_walk;   // empty the stack and the used mask, position to zero
    logic load_r;     // position to r, ready to backtrack
    logic fill_step;  // push the smallest unused value at the position
    logic back_step;  // pop or bump the value below the position
    logic capture;    // load the result register
    logic res_valid;  // the captured result holds a permutation
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_at_r;     // position has reached r
    logic p_zero;     // position is at the bottom of the stack
    logic found;      // backtrack step found a larger free value
    logic out_free;   // result register can take a new item
  } sts_t;

  // Values 1..n as a mask: bit k stands for value k+1.
  function automatic vmask_t le_mask(input cnt_t n);
    vmask_t m;
    for (int k = 0; k < MAX_N; k++) begin
      m[k] = (k < int'(n));
    end
    return m;
  endfunction

  // Values strictly above v as a mask.
  function automatic vmask_t above_mask(input cnt_t v);
    vmask_t m;
    for (int k = 0; k < MAX_N; k++) begin
      m[k] = (k >= int'(v));
    end
    return m;
  endfunction

  // One-hot mask bit for value v; zero when v is not a value.
  function automatic vmask_t bit_of(input cnt_t v);
    vmask_t m;
    m = '0;
    for (int k = 0; k < MAX_N; k++) begin
      if (int'(v) == k + 1) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

  // Smallest value whose bit is set in avail, or zero when none is.
  function automatic cnt_t first_free(input vmask_t avail);
    cnt_t v;
    v = '0;
    for (int k = MAX_N - 1; k >= 0; k--) begin
      if (avail[k]) begin
        v = cnt_t'(k + 1);
      end
    end
    return v;
  endfunction

endpackage

### rtl/kpe_intf.sv
// Request channel: one item asks for the next permutation or a rewind.
interface kpe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Result channel: one item per request.
interface kpe_out_if;
  logic                      valid;
  logic                      ready;
  logic                      perm_valid;
  logic                      is_final;
  logic [kpe_pkg::ELEM_W-1:0] elem_0;
  logic [kpe_pkg::ELEM_W-1:0] elem_1;
  logic [kpe_pkg::ELEM_W-1:0] elem_2;
  logic [kpe_pkg::ELEM_W-1:0] elem_3;
  logic [kpe_pkg::ELEM_W-1:0] elem_4;
  logic [kpe_pkg::ELEM_W-1:0] elem_5;
  logic [kpe_pkg::ELEM_W-1:0] elem_6;
  logic [kpe_pkg::ELEM_W-1:0] elem_7;

  modport source (output valid, output perm_valid, output is_final,
                  output elem_0, output elem_1, output elem_2, output elem_3,
                  output elem_4, output elem_5, output elem_6, output elem_7,
                  input ready);
  modport sink (input valid, input perm_valid, input is_final,
                input elem_0, input elem_1, input elem_2, input elem_3,
                input elem_4, input elem_5, input elem_6, input elem_7,
                output ready);
endinterface

### rtl/kpe_datapath.sv
module kpe_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  kpe_pkg::cnt_t      n,
  input  kpe_pkg::cnt_t      r,
  input  kpe_pkg::cmd_t      cmd,
  output kpe_pkg::sts_t      sts,
  kpe_out_if.source          out_ch
);

  // Search stack, used-value mask and current position.
  kpe_pkg::cnt_t  stack_r [kpe_pkg::MAX_N];
  kpe_pkg::vmask_t mask_r;
  kpe_pkg::cnt_t  p_r;

  // Result register.
  logic                        out_valid_r;
  logic                        out_perm_valid_r;
  logic                        out_is_final_r;
  logic [kpe_pkg::ELEM_W-1:0]  out_elem_r [kpe_pkg::NUM_ELEMS];

  kpe_pkg::cnt_t   q;
  logic [kpe_pkg::IDX_W-1:0] fill_idx;
  logic [kpe_pkg::IDX_W-1:0] back_idx;
  kpe_pkg::cnt_t   fill_val;
  kpe_pkg::cnt_t   top_val;
  kpe_pkg::vmask_t back_mask;
  kpe_pkg::cnt_t   bump_val;
  logic            last_perm;

  // Position below the current one, where a backtrack step works.
  assign q        = p_r - kpe_pkg::cnt_t'(1);
  assign fill_idx = p_r[kpe_pkg::IDX_W-1:0];
  assign back_idx = q[kpe_pkg::IDX_W-1:0];

  // Smallest unused value for a forward fill.
  assign fill_val = kpe_pkg::first_free(~mask_r & kpe_pkg::le_mask(n));

  // Backtrack: release the value on top, then look for a larger free one.
  assign top_val   = stack_r[back_idx];
  assign back_mask = mask_r & ~kpe_pkg::bit_of(top_val);
  assign bump_val  = kpe_pkg::first_free(~back_mask & kpe_pkg::le_mask(n) &
                                         kpe_pkg::above_mask(top_val));

  // The last permutation is n, n-1, ..., n-r+1.
  always_comb begin
    last_perm = 1'b1;
    for (int i = 0; i < kpe_pkg::MAX_N; i++) begin
      if ((i < int'(r)) && (stack_r[i] != kpe_pkg::cnt_t'(int'(n) - i))) begin
        last_perm = 1'b0;
      end
    end
  end

  assign sts.p_at_r   = (p_r == r);
  assign sts.p_zero   = (p_r == '0);
  assign sts.found    = (bump_val != '0);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Stack walk.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_walk) begin
      for (int i = 0; i < kpe_pkg::MAX_N; i++) begin
        stack_r[i] <= '0;
      end
      mask_r <= '0;
      p_r    <= '0;
    end else if (cmd.load_r) begin
      p_r <= r;
    end else if (cmd.fill_step) begin
      stack_r[fill_idx] <= fill_val;
      mask_r            <= mask_r | kpe_pkg::bit_of(fill_val);
      p_r               <= p_r + kpe_pkg::cnt_t'(1);
    end else if (cmd.back_step) begin
      stack_r[back_idx] <= bump_val;
      mask_r            <= back_mask | kpe_pkg::bit_of(bump_val);
      if (bump_val != '0) begin
        p_r <= q + kpe_pkg::cnt_t'(1);
      end else begin
        p_r <= q;
      end
    end
  end

  // Result handshake flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; everything reads zero when no permutation is given.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_perm_valid_r <= cmd.res_valid;
      out_is_final_r   <= cmd.res_valid && last_perm;
      for (int i = 0; i < kpe_pkg::NUM_ELEMS; i++) begin
        out_elem_r[i] <= '0;
        if (i < kpe_pkg::MAX_N) begin
          if (cmd.res_valid && (i < int'(r))) begin
            out_elem_r[i] <= kpe_pkg::ELEM_W'(stack_r[i]);
          end
        end
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.perm_valid = out_perm_valid_r;
  assign out_ch.is_final   = out_is_final_r;
  assign out_ch.elem_0     = out_elem_r[0];
  assign out_ch.elem_1     = out_elem_r[1];
  assign out_ch.elem_2     = out_elem_r[2];
  assign out_ch.elem_3     = out_elem_r[3];
  assign out_ch.elem_4     = out_elem_r[4];
  assign out_ch.elem_5     = out_elem_r[5];
  assign out_ch.elem_6     = out_elem_r[6];
  assign out_ch.elem_7     = out_elem_r[7];

endmodule

### rtl/kpe_ctrl.sv
module kpe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  input  logic          cfg_we,
  input  kpe_pkg::cnt_t n,
  input  kpe_pkg::cnt_t r,
  input  kpe_pkg::sts_t sts,
  output kpe_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_BACK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       started_r, started_nxt;
  logic       exhausted_r, exhausted_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic       st_eff;
  logic       ex_eff;

  assign in_ready = (state_r == ST_IDLE);

  // A restart item sees the walk as freshly rewound.
  assign st_eff = started_r && !in_restart;
  assign ex_eff = exhausted_r && !in_restart;

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    res_valid_nxt = res_valid_r;
    cmd           = '0;

    if (cfg_we) begin
      started_nxt   = 1'b0;
      exhausted_nxt = 1'b0;
      cmd.clr_walk  = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            cmd.clr_walk  = 1'b1;
            started_nxt   = 1'b0;
            exhausted_nxt = 1'b0;
          end
          if (ex_eff) begin
            res_valid_nxt = 1'b0;
            state_nxt     = ST_DONE;
          end else if (!st_eff) begin
            started_nxt = 1'b1;
            if (r > n) begin
              exhausted_nxt = 1'b1;
              res_valid_nxt = 1'b0;
              state_nxt     = ST_DONE;
            end else begin
              cmd.clr_walk = 1'b1;
              state_nxt    = ST_FILL;
            end
          end else begin
            cmd.load_r = 1'b1;
            state_nxt  = ST_BACK;
          end
        end
      end
      ST_FILL: begin
        if (sts.p_at_r) begin
          res_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_BACK: begin
        if (sts.p_zero) begin
          exhausted_nxt = 1'b1;
          res_valid_nxt = 1'b0;
          state_nxt     = ST_DONE;
        end else begin
          cmd.back_step = 1'b1;
          if (sts.found) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.capture   = 1'b1;
          cmd.res_valid = res_valid_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

endmodule

### rtl/k_permutation_enumerator.sv
// Lists the ordered selections of r distinct values from 1..n in lexicographic
// order, one per request item; a request with restart set rewinds to 1..r, and
// once the last selection has gone out every request answers perm_valid 0.
// Writing either register (set_size at byte 0, pick_count at byte 4; values
// above 8 act as 8) also rewinds. The walk is a stack held in flip-flops and
// worked one position per cycle: a first or rewound request fills the
// positions from the bottom with the smallest free values, and a later one
// backtracks until a larger free value is found and refills the positions
// above it. The result sits in an output register, and the next request is
// taken while it waits.
module k_permutation_enumerator (
  input  logic        clk,
  input  logic        rst_n,
  kpe_in_if.sink      in_ch,
  kpe_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_SET_SIZE   = 1'b0;
  localparam logic REG_PICK_COUNT = 1'b1;

  logic [kpe_pkg::ELEM_W-1:0] set_size_r;
  logic [kpe_pkg::ELEM_W-1:0] pick_count_r;
  logic                       cfg_we;
  kpe_pkg::cnt_t              n_eff;
  kpe_pkg::cnt_t              r_eff;
  kpe_pkg::cmd_t              cmd;
  kpe_pkg::sts_t              sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r   <= kpe_pkg::ELEM_W'(4);
      pick_count_r <= kpe_pkg::ELEM_W'(2);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_SET_SIZE:   set_size_r   <= pwdata[kpe_pkg::ELEM_W-1:0];
        REG_PICK_COUNT: pick_count_r <= pwdata[kpe_pkg::ELEM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_SET_SIZE:   prdata = 32'(set_size_r);
      REG_PICK_COUNT: prdata = 32'(pick_count_r);
      default:        prdata = '0;
    endcase
  end

  // Saturate n and r to the supported set size.
  assign n_eff = (int'(set_size_r) > kpe_pkg::MAX_N) ?
                 kpe_pkg::cnt_t'(kpe_pkg::MAX_N) : kpe_pkg::cnt_t'(set_size_r);
  assign r_eff = (int'(pick_count_r) > kpe_pkg::MAX_N) ?
                 kpe_pkg::cnt_t'(kpe_pkg::MAX_N) : kpe_pkg::cnt_t'(pick_count_r);

  kpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .cfg_we     (cfg_we),
    .n          (n_eff),
    .r          (r_eff),
    .sts        (sts),
    .cmd        (cmd)
  );

  kpe_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .n      (n_eff),
    .r      (r_eff),
    .cmd    (cmd),
    .sts    (sts),
    .out_ch (out_ch)
  );

endmodule
